// ===== design/s2u64_pkg.sv =====
// Shared types, constants and the character classifier for the string to
// 64-bit unsigned integer parser. No dependencies.

package s2u64_pkg;

  // Character count saturates here; the reported count is its low 8 bits.
  localparam int unsigned MaxCount = 255;
  localparam int unsigned CountW   = $clog2(MaxCount + 1);

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned ConsW  = 8;
  localparam int unsigned RadixW = 6;
  localparam int unsigned DigitW = 6;
  localparam int unsigned ProdW  = ValueW + RadixW;
  localparam int unsigned ExtW   = (CountW > ConsW) ? CountW : ConsW;

  // APB data width and the register map (word index taken from paddr[2]).
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam logic        RegRadix = 1'b0;

  localparam logic [RadixW-1:0] BaseDetect = 6'd0;
  localparam logic [RadixW-1:0] BaseOne    = 6'd1;
  localparam logic [RadixW-1:0] BaseTwo    = 6'd2;
  localparam logic [RadixW-1:0] BaseOct    = 6'd8;
  localparam logic [RadixW-1:0] BaseDec    = 6'd10;
  localparam logic [RadixW-1:0] BaseHex    = 6'd16;
  localparam logic [RadixW-1:0] BaseMax    = 6'd36;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7a;
  localparam logic [CharW-1:0] DigitTen = 8'd10;

  // Above every legal base, so it never passes the digit-below-base test.
  localparam logic [DigitW-1:0] NoDigit = 6'd63;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             start_req;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [ConsW-1:0]  consumed;
    logic              any_digits;
    logic              overflow;
  } out_item_t;

  function automatic logic [DigitW-1:0] digit_of(logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    d = NoDigit;
    if (c >= ChZero && c <= ChNine) begin
      d = DigitW'(c - ChZero);
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = DigitW'(c - ChUpA + DigitTen);
    end else if (c >= ChLowA && c <= ChLowZ) begin
      d = DigitW'(c - ChLowA + DigitTen);
    end
    return d;
  endfunction

endpackage

// ===== design/string_to_uint64_parser.sv =====
// Character-serial text to 64-bit unsigned integer converter (strtoull style).
// Flow: a terminating character is registered in the input register and its
//   result in the result register; a stalled pending result holds the emit.
// Throughput: one character per cycle unless a stalled result holds an emit; the
//   multiply-add by the base sits between input and state/result registers.
// Reset: radix returns to 10, the parser goes idle and no result is pending.
// Depends on s2u64_pkg.

module string_to_uint64_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  s2u64_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output s2u64_pkg::out_item_t                out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [s2u64_pkg::ApbAddrW-1:0]      paddr,
  input  logic [s2u64_pkg::ApbDataW-1:0]      pwdata,
  output logic [s2u64_pkg::ApbDataW-1:0]      prdata,
  output logic                                pready
);

  typedef enum logic [2:0] {
    PhIdle,
    PhSpaces,
    PhSigned,
    PhZero,
    PhDigits
  } phase_e;

  logic [s2u64_pkg::RadixW-1:0] radix_q;

  logic                 in_valid_q;
  s2u64_pkg::in_item_t  in_q;
  logic                 out_valid_q;
  s2u64_pkg::out_item_t out_q;

  phase_e                        phase_q, phase_d;
  logic [s2u64_pkg::ValueW-1:0]  acc_q, acc_d;
  logic                          neg_q, neg_d;
  logic [s2u64_pkg::RadixW-1:0]  base_q, base_d;
  logic                          seen_q, seen_d;
  logic                          sat_q, sat_d;
  logic [s2u64_pkg::CountW-1:0]  cnt_q, cnt_d;

  logic                          bump;
  logic                          sign_path;
  logic                          to_digits;
  logic                          emit;
  logic [s2u64_pkg::RadixW-1:0]  eff_base;
  logic [s2u64_pkg::DigitW-1:0]  dig;
  logic [s2u64_pkg::ProdW-1:0]   prod;
  logic [s2u64_pkg::ExtW-1:0]    cnt_ext;
  s2u64_pkg::out_item_t          res;
  logic                          adv;
  logic                          cfg_wr;

  // One character step over the registered input item.
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    base_d    = base_q;
    seen_d    = seen_q;
    sat_d     = sat_q;
    cnt_d     = cnt_q;
    bump      = 1'b0;
    sign_path = 1'b0;
    to_digits = 1'b0;
    emit      = 1'b0;
    prod      = '0;
    eff_base  = s2u64_pkg::BaseDec;
    dig       = s2u64_pkg::digit_of(in_q.ch);

    if (in_q.start_req) begin
      acc_d   = '0;
      neg_d   = 1'b0;
      seen_d  = 1'b0;
      sat_d   = 1'b0;
      cnt_d   = '0;
      phase_d = PhSpaces;
      if (radix_q == s2u64_pkg::BaseOne || radix_q > s2u64_pkg::BaseMax) begin
        base_d = s2u64_pkg::BaseDec;
      end else begin
        base_d = radix_q;
      end
    end

    case (phase_d)
      PhIdle: begin
      end
      PhSpaces: begin
        if (in_q.ch == s2u64_pkg::ChSpace) begin
          bump = 1'b1;
        end else if (in_q.ch == s2u64_pkg::ChMinus || in_q.ch == s2u64_pkg::ChPlus) begin
          neg_d   = (in_q.ch == s2u64_pkg::ChMinus);
          bump    = 1'b1;
          phase_d = PhSigned;
        end else begin
          sign_path = 1'b1;
        end
      end
      PhSigned: begin
        sign_path = 1'b1;
      end
      PhZero: begin
        if (in_q.ch == s2u64_pkg::ChLowX || in_q.ch == s2u64_pkg::ChUpX) begin
          base_d  = s2u64_pkg::BaseHex;
          bump    = 1'b1;
          phase_d = PhDigits;
        end else begin
          // The leading zero counts as a digit once no prefix follows.
          if (base_d == s2u64_pkg::BaseDetect) begin
            base_d = s2u64_pkg::BaseOct;
          end
          seen_d    = 1'b1;
          to_digits = 1'b1;
        end
      end
      PhDigits: begin
        to_digits = 1'b1;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    if (sign_path) begin
      if ((base_d == s2u64_pkg::BaseDetect || base_d == s2u64_pkg::BaseHex) &&
          in_q.ch == s2u64_pkg::ChZero) begin
        bump    = 1'b1;
        phase_d = PhZero;
      end else begin
        if (base_d == s2u64_pkg::BaseDetect) begin
          base_d = s2u64_pkg::BaseDec;
        end
        to_digits = 1'b1;
      end
    end

    if (to_digits) begin
      phase_d  = PhDigits;
      eff_base = (base_d < s2u64_pkg::BaseTwo) ? s2u64_pkg::BaseDec : base_d;
      if (dig < eff_base) begin
        // Overflow shows as any set bit above the low 64 of the product.
        prod = s2u64_pkg::ProdW'(acc_d) * s2u64_pkg::ProdW'(eff_base) +
               s2u64_pkg::ProdW'(dig);
        if (sat_d || prod[s2u64_pkg::ProdW-1:s2u64_pkg::ValueW] != '0) begin
          sat_d = 1'b1;
        end else begin
          acc_d = prod[s2u64_pkg::ValueW-1:0];
        end
        seen_d = 1'b1;
        bump   = 1'b1;
      end else begin
        emit    = 1'b1;
        phase_d = PhIdle;
      end
    end

    if (bump && cnt_d < s2u64_pkg::CountW'(s2u64_pkg::MaxCount)) begin
      cnt_d = cnt_d + 1'b1;
    end
  end

  assign cnt_ext = s2u64_pkg::ExtW'(cnt_d);

  always_comb begin
    if (sat_d) begin
      res.value = '1;
    end else if (!seen_d) begin
      res.value = '0;
    end else if (neg_d) begin
      res.value = '0 - acc_d;
    end else begin
      res.value = acc_d;
    end
    res.consumed   = seen_d ? cnt_ext[s2u64_pkg::ConsW-1:0] : '0;
    res.any_digits = seen_d;
    res.overflow   = sat_d;
  end

  // The step only waits when it would emit into a full, stalled result register.
  assign adv        = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == s2u64_pkg::RegRadix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= s2u64_pkg::BaseDec;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhIdle;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      base_q      <= s2u64_pkg::BaseDetect;
      seen_q      <= 1'b0;
      sat_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_wr) begin
        radix_q <= pwdata[s2u64_pkg::RadixW-1:0];
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        base_q  <= base_d;
        seen_q  <= seen_d;
        sat_q   <= sat_d;
        cnt_q   <= cnt_d;
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (adv && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == s2u64_pkg::RegRadix) ?
                  s2u64_pkg::ApbDataW'(radix_q) : '0;

endmodule

// ===== design/s2u64_checker.sv =====
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on s2u64_pkg and string_to_uint64_parser.

module s2u64_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input s2u64_pkg::out_item_t out_data_o
);

  // A number with no digits reports zero everywhere and cannot overflow.
  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.any_digits |->
      out_data_o.value == '0 && out_data_o.consumed == '0 && !out_data_o.overflow)
    else $error("result without digits is not all zero");

  // Overflow saturates the value to all ones, regardless of sign.
  a_overflow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.value == '1)
    else $error("overflowed result is not saturated");

  // A stalled result transaction stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

endmodule

bind string_to_uint64_parser s2u64_checker u_s2u64_checker (.*);
